// File: src/ghm_pkg.sv
// ----------------------------------------------------------------------------
// ghm_pkg: shared types and constants of the grouped histogram mode block
// Field widths of the request and result ports, and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ghm_pkg;

    localparam int GROUP_W       = 3;
    localparam int ALLELE_W      = 8;
    localparam int GROUP_COUNT_W = 4;
    localparam int MAJOR_W       = 4;

    localparam logic [GROUP_COUNT_W-1:0] GROUP_COUNT_RESET = 4'd8;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;          // capture the request fields and start the counter read
        logic inc;           // write back the incremented counter
        logic sweep;         // read and zero one counter per cycle
        logic emit;          // the current sweep reports results
        logic clear_dropped; // the record is finished
    } ghm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic item_eor;      // the captured request ends a record
        logic sweep_last;    // the sweep is at its final counter
    } ghm_status_t;

endpackage

// File: src/ghm_ctrl.sv
// ----------------------------------------------------------------------------
// ghm_ctrl: sequencing state machine
// Steps each request through its counter update and, at record end, through
// the sweep that reports and clears every counter.
// ----------------------------------------------------------------------------
module ghm_ctrl
    import ghm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  ghm_status_t status,
    output ghm_cmd_t    cmd,
    output logic        busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_INC,
        S_SWEEP,
        S_DRAIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;
    logic   emit_reg;
    logic   emit_next;

    always_comb
    begin
        state_next = state_reg;
        emit_next  = emit_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_INC;
                end
            end
            S_INC:
            begin
                if (status.item_eor)
                begin
                    state_next = S_SWEEP;
                    emit_next  = 1'b1;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SWEEP:
            begin
                if (status.sweep_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_IDLE;
                emit_next  = 1'b0;
            end
            default:
            begin
                state_next = S_IDLE;
                emit_next  = 1'b0;
            end
        endcase
        busy_next = (state_next != S_IDLE);
    end

    // The reset state is a sweep without results, which zeroes the counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SWEEP;
            busy_reg  <= 1'b1;
            emit_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            emit_reg  <= emit_next;
        end
    end

    always_comb
    begin
        cmd.load          = start && (state_reg == S_IDLE);
        cmd.inc           = (state_reg == S_INC);
        cmd.sweep         = (state_reg == S_SWEEP);
        cmd.emit          = emit_reg;
        cmd.clear_dropped = (state_reg == S_DRAIN) && emit_reg;
    end

    assign busy = busy_reg;

endmodule

// File: src/ghm_datapath.sv
// ----------------------------------------------------------------------------
// ghm_datapath: counter memory, update path and argmax scan
// Holds the per-group allele counters in one memory, performs the
// saturating read-modify-write for each request and runs the sweep that
// finds each group's most frequent allele while zeroing the counters.
// ----------------------------------------------------------------------------
module ghm_datapath
    import ghm_pkg::*;
#(
    parameter int MAX_GROUPS  = 8,
    parameter int MAX_ALLELES = 16,
    parameter int COUNT_WIDTH = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [GROUP_W-1:0]       group,
    input  logic [ALLELE_W-1:0]      allele,
    input  logic                     end_of_record,
    input  logic                     cfg_wr_en,
    input  logic [GROUP_COUNT_W-1:0] cfg_wr_data,
    input  ghm_cmd_t                 cmd,
    output ghm_status_t              status,
    output logic                     result_strobe,
    output logic [GROUP_W-1:0]       group_index,
    output logic [MAJOR_W-1:0]       major_allele,
    output logic                     dropped,
    output logic                     last
);

    localparam int GW        = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int AW        = $clog2(MAX_ALLELES);
    localparam int MEM_DEPTH = 2 ** (GW + AW);
    localparam int NW0       = $clog2(MAX_GROUPS + 1);
    localparam int NW        = (NW0 > GROUP_COUNT_W) ? NW0 : GROUP_COUNT_W;
    localparam int AXW       = ALLELE_W + 1;

    logic [COUNT_WIDTH-1:0]   count_mem [0:MEM_DEPTH-1];

    logic [GROUP_COUNT_W-1:0] group_count_reg;
    logic                     dropped_reg;

    logic [GW-1:0]            item_row_reg;
    logic [AW-1:0]            item_col_reg;
    logic                     item_ok_reg;
    logic                     item_drop_reg;
    logic                     item_eor_reg;

    logic [GW-1:0]            sweep_row_reg;
    logic [GW-1:0]            sweep_row_next;
    logic [AW-1:0]            sweep_col_reg;
    logic [AW-1:0]            sweep_col_next;

    logic [COUNT_WIDTH-1:0]   rd_data_reg;
    logic [GW+AW-1:0]         rd_addr;
    logic [GW+AW-1:0]         item_addr;
    logic                     wr_en;
    logic [GW+AW-1:0]         wr_addr;
    logic [COUNT_WIDTH-1:0]   wr_data;

    logic                     st_valid_reg;
    logic                     st_emit_reg;
    logic [GW-1:0]            st_row_reg;
    logic [AW-1:0]            st_col_reg;

    logic [COUNT_WIDTH-1:0]   best_cnt_reg;
    logic [COUNT_WIDTH-1:0]   best_cnt_next;
    logic [AW-1:0]            best_idx_reg;
    logic [AW-1:0]            best_idx_next;

    logic [NW-1:0]            gc_ext;
    logic [NW-1:0]            n_eff;
    logic                     row_end;
    logic                     row_reported;
    logic                     row_last;

    logic                     strobe_reg;
    logic [GROUP_W-1:0]       group_index_reg;
    logic [MAJOR_W-1:0]       major_reg;
    logic                     dropped_out_reg;
    logic                     last_reg;

    logic                     in_group_ok;
    logic                     in_allele_ok;

    // Request decode.
    assign in_group_ok  = NW'(group) < NW'(MAX_GROUPS);
    assign in_allele_ok = AXW'(allele) < AXW'(MAX_ALLELES);
    assign item_addr    = {GW'(group), AW'(allele)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_count_reg <= GROUP_COUNT_RESET;
        end
        else if (cfg_wr_en)
        begin
            group_count_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_row_reg  <= GW'(group);
            item_col_reg  <= AW'(allele);
            item_ok_reg   <= in_group_ok && in_allele_ok;
            item_drop_reg <= !in_allele_ok;
            item_eor_reg  <= end_of_record;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dropped_reg <= 1'b0;
        end
        else if (cmd.clear_dropped)
        begin
            dropped_reg <= 1'b0;
        end
        else if (cmd.inc && item_drop_reg)
        begin
            dropped_reg <= 1'b1;
        end
    end

    // Sweep address: allele in the low counter, group in the high one.
    always_comb
    begin
        sweep_row_next = sweep_row_reg;
        sweep_col_next = sweep_col_reg + AW'(1);
        if (sweep_col_reg == AW'(MAX_ALLELES - 1))
        begin
            sweep_col_next = '0;
            if (sweep_row_reg == GW'(MAX_GROUPS - 1))
            begin
                sweep_row_next = '0;
            end
            else
            begin
                sweep_row_next = sweep_row_reg + GW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_row_reg <= '0;
            sweep_col_reg <= '0;
        end
        else if (cmd.sweep)
        begin
            sweep_row_reg <= sweep_row_next;
            sweep_col_reg <= sweep_col_next;
        end
    end

    // Counter memory: one read and one write port, registered read data.
    always_comb
    begin
        rd_addr = cmd.sweep ? {sweep_row_reg, sweep_col_reg} : item_addr;
        wr_en   = 1'b0;
        wr_addr = {item_row_reg, item_col_reg};
        wr_data = rd_data_reg;
        if (cmd.sweep)
        begin
            wr_en   = 1'b1;
            wr_addr = {sweep_row_reg, sweep_col_reg};
            wr_data = '0;
        end
        else if (cmd.inc && item_ok_reg)
        begin
            wr_en = 1'b1;
            if (rd_data_reg != '1)
            begin
                wr_data = rd_data_reg + COUNT_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= count_mem[rd_addr];
        if (wr_en)
        begin
            count_mem[wr_addr] <= wr_data;
        end
    end

    // Compare stage, fed by the registered sweep read data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg <= 1'b0;
            st_emit_reg  <= 1'b0;
        end
        else
        begin
            st_valid_reg <= cmd.sweep;
            st_emit_reg  <= cmd.sweep && cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        st_row_reg <= sweep_row_reg;
        st_col_reg <= sweep_col_reg;
    end

    always_comb
    begin
        best_cnt_next = best_cnt_reg;
        best_idx_next = best_idx_reg;
        if (st_col_reg == '0)
        begin
            best_cnt_next = rd_data_reg;
            best_idx_next = '0;
        end
        else if (rd_data_reg > best_cnt_reg)
        begin
            best_cnt_next = rd_data_reg;
            best_idx_next = st_col_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_valid_reg)
        begin
            best_cnt_reg <= best_cnt_next;
            best_idx_reg <= best_idx_next;
        end
    end

    // A group count of zero reports one group; a large one is capped.
    always_comb
    begin
        gc_ext = NW'(group_count_reg);
        if (gc_ext == '0)
        begin
            n_eff = NW'(1);
        end
        else if (gc_ext > NW'(MAX_GROUPS))
        begin
            n_eff = NW'(MAX_GROUPS);
        end
        else
        begin
            n_eff = gc_ext;
        end
    end

    assign row_end      = st_col_reg == AW'(MAX_ALLELES - 1);
    assign row_reported = NW'(st_row_reg) < n_eff;
    assign row_last     = NW'(st_row_reg) == (n_eff - NW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= st_valid_reg && st_emit_reg && row_end && row_reported;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_valid_reg && row_end)
        begin
            group_index_reg <= GROUP_W'(st_row_reg);
            major_reg       <= MAJOR_W'(best_idx_next);
            dropped_out_reg <= dropped_reg;
            last_reg        <= row_last;
        end
    end

    assign status.item_eor   = item_eor_reg;
    assign status.sweep_last = (sweep_row_reg == GW'(MAX_GROUPS - 1))
                            && (sweep_col_reg == AW'(MAX_ALLELES - 1));

    assign result_strobe = strobe_reg;
    assign group_index   = group_index_reg;
    assign major_allele  = major_reg;
    assign dropped       = dropped_out_reg;
    assign last          = last_reg;

endmodule

// File: src/grouped_histogram_mode.sv
// ----------------------------------------------------------------------------
// grouped_histogram_mode: per-group most frequent allele over a record
// Counts allele calls per sample group and, at each record end, reports
// the allele with the highest count for every configured group.
// ----------------------------------------------------------------------------
// Usage. A request (group, allele, end_of_record) is taken at a rising edge
// where start is high and busy is low. Each request increments the counter
// of its group and allele, saturating at the top of COUNT_WIDTH bits. An
// allele at or beyond MAX_ALLELES is not counted and marks the record as
// dropped. The one register, group_count, is written through cfg_wr_en and
// cfg_wr_data; the user must write it only while the block is idle, as the
// block itself does not enforce this. It resets to eight groups.
// Timing. An ordinary request keeps busy high while its counter is read
// and then written back, so the block takes no new request before it is
// through with the last one. A request that ends a record starts a sweep
// over all MAX_GROUPS * MAX_ALLELES counters in the counter memory, one
// counter per cycle, which finds each group's maximum (lowest allele on a
// tie, allele 0 for an empty group) and zeroes the counter behind it. Busy
// stays high through the sweep and the drain state that follows it. The
// results come group by group in ascending order; each result is shown
// for one cycle with result_strobe high and last marks the final one.
// The receiver cannot stall. After reset the same sweep runs once without
// results to zero the memory, with busy high.
// ----------------------------------------------------------------------------
module grouped_histogram_mode
    import ghm_pkg::*;
#(
    parameter int MAX_GROUPS  = 8,
    parameter int MAX_ALLELES = 16,
    parameter int COUNT_WIDTH = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [GROUP_W-1:0]       group,
    input  logic [ALLELE_W-1:0]      allele,
    input  logic                     end_of_record,
    input  logic                     cfg_wr_en,
    input  logic [GROUP_COUNT_W-1:0] cfg_wr_data,
    output logic                     result_strobe,
    output logic [GROUP_W-1:0]       group_index,
    output logic [MAJOR_W-1:0]       major_allele,
    output logic                     dropped,
    output logic                     last
);

    ghm_cmd_t    cmd;
    ghm_status_t status;

    // The controller sequences the update and the sweep.
    ghm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // The datapath owns the counters, the register and the result stage.
    ghm_datapath #(
        .MAX_GROUPS  (MAX_GROUPS),
        .MAX_ALLELES (MAX_ALLELES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .group         (group),
        .allele        (allele),
        .end_of_record (end_of_record),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .cmd           (cmd),
        .status        (status),
        .result_strobe (result_strobe),
        .group_index   (group_index),
        .major_allele  (major_allele),
        .dropped       (dropped),
        .last          (last)
    );

    // A taken request always makes the block busy on the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after a request was taken");

    // Results only come out of a sweep, which runs with busy high.
    a_result_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(busy))
        else $error("result outside of a sweep");

    // The last result of a record is not followed directly by another.
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && last) |=> !result_strobe)
        else $error("result right after the last one");

    // Results of one record come one group scan apart.
    a_result_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !last) |-> ##MAX_ALLELES result_strobe)
        else $error("next group result missing");

endmodule
